// ===== src/u8u16_pkg.sv =====
`timescale 1ns / 1ps

package u8u16_pkg;

  // one byte of utf-8 text as it arrives
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  // one utf-16 code unit as it leaves
  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_replacement;
    logic        last_of_run;
  } out_item_t;

  // accumulator width: four-byte sequences carry 21 bits, longer ones are always replaced
  localparam int unsigned ACC_W = 21;

  localparam int unsigned DEF_FIFO_DEPTH = 4;

  // what the decoder hands to the output queue for one byte
  typedef struct packed {
    logic [1:0] count;
    out_item_t  unit0;
    out_item_t  unit1;
  } dec_result_t;

  localparam logic [15:0] REPL_CHAR     = 16'hFFFD;
  localparam logic [15:0] SUR_HIGH_BASE = 16'hD800;
  localparam logic [15:0] SUR_LOW_BASE  = 16'hDC00;

  localparam logic [ACC_W-1:0] MIN_TWO     = 21'h000080;
  localparam logic [ACC_W-1:0] MIN_THREE   = 21'h000800;
  localparam logic [ACC_W-1:0] SUPP_BASE   = 21'h010000;
  localparam logic [ACC_W-1:0] SUR_FIRST   = 21'h00D800;
  localparam logic [ACC_W-1:0] SUR_LAST    = 21'h00DFFF;
  localparam logic [ACC_W-1:0] NONCHAR_LO  = 21'h00FFFE;
  localparam logic [ACC_W-1:0] NONCHAR_HI  = 21'h00FFFF;
  localparam logic [ACC_W-1:0] MAX_CODE    = 21'h10FFFF;

endpackage

// ===== src/u8u16_decode.sv =====
`timescale 1ns / 1ps

module u8u16_decode import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  in_item_t    item,
  output dec_result_t result
);

  logic [2:0]       bytes_remaining;
  logic [2:0]       sequence_length;
  logic [ACC_W-1:0] code_accum;

  logic [2:0]       bytes_remaining_next;
  logic [2:0]       sequence_length_next;
  logic [ACC_W-1:0] code_accum_next;

  logic             cont;
  logic [ACC_W-1:0] cp;
  logic [2:0]       rem_dec;
  logic             bad;
  logic [ACC_W-1:0] supp_off;
  logic             is_ascii;
  logic             is_lead;
  logic [2:0]       trail;
  logic [4:0]       lead_bits;
  logic [1:0]       n;
  out_item_t        units [2];
  out_item_t        fresh_unit;
  logic             fresh_put;

  always_comb begin
    cont      = (item.in_byte[7:6] == 2'b10);
    cp        = {code_accum[ACC_W-7:0], item.in_byte[5:0]};
    rem_dec   = bytes_remaining - 3'd1;
    supp_off  = cp - SUPP_BASE;

    // overlong, too long, surrogate, non-character or out of range
    case (sequence_length)
      3'd2:    bad = (cp < MIN_TWO);
      3'd3:    bad = (cp < MIN_THREE);
      3'd4:    bad = (cp < SUPP_BASE);
      default: bad = 1'b1;
    endcase
    if ((cp >= SUR_FIRST && cp <= SUR_LAST) || cp == NONCHAR_LO || cp == NONCHAR_HI ||
        cp > MAX_CODE) begin
      bad = 1'b1;
    end

    // lead byte classification
    is_ascii  = ~item.in_byte[7];
    is_lead   = 1'b1;
    trail     = 3'd0;
    lead_bits = 5'd0;
    if (item.in_byte[7:5] == 3'b110) begin
      trail = 3'd1; lead_bits = item.in_byte[4:0];
    end else if (item.in_byte[7:4] == 4'b1110) begin
      trail = 3'd2; lead_bits = {1'b0, item.in_byte[3:0]};
    end else if (item.in_byte[7:3] == 5'b11110) begin
      trail = 3'd3; lead_bits = {2'b0, item.in_byte[2:0]};
    end else if (item.in_byte[7:2] == 6'b111110) begin
      trail = 3'd4; lead_bits = {3'b0, item.in_byte[1:0]};
    end else if (item.in_byte[7:1] == 7'b1111110) begin
      trail = 3'd5; lead_bits = {4'b0, item.in_byte[0]};
    end else begin
      is_lead = 1'b0;
    end

    n                    = 2'd0;
    units[0]             = '{code_unit: REPL_CHAR, is_replacement: 1'b1, last_of_run: 1'b0};
    units[1]             = units[0];
    bytes_remaining_next = bytes_remaining;
    sequence_length_next = sequence_length;
    code_accum_next      = code_accum;
    fresh_unit           = units[0];
    fresh_put            = 1'b0;

    if (bytes_remaining != 3'd0 && cont) begin
      if (rem_dec == 3'd0) begin
        if (bad) begin
          n = 2'd1;
        end else if (cp < SUPP_BASE) begin
          n = 2'd1;
          units[0] = '{code_unit: cp[15:0], is_replacement: 1'b0, last_of_run: 1'b0};
        end else begin
          n = 2'd2;
          units[0] = '{code_unit: SUR_HIGH_BASE + {6'b0, supp_off[19:10]},
                       is_replacement: 1'b0, last_of_run: 1'b0};
          units[1] = '{code_unit: SUR_LOW_BASE + {6'b0, supp_off[9:0]},
                       is_replacement: 1'b0, last_of_run: 1'b0};
        end
        bytes_remaining_next = 3'd0;
        sequence_length_next = 3'd0;
        code_accum_next      = '0;
      end else if (item.end_of_input) begin
        n = 2'd1;
      end else begin
        bytes_remaining_next = rem_dec;
        code_accum_next      = cp;
      end
    end else begin
      // a cut sequence gives a replacement before the byte is decoded afresh
      if (bytes_remaining != 3'd0) begin
        n = 2'd1;
      end
      bytes_remaining_next = 3'd0;
      sequence_length_next = 3'd0;
      code_accum_next      = '0;
      if (is_ascii) begin
        fresh_put  = 1'b1;
        fresh_unit = '{code_unit: {8'h00, item.in_byte}, is_replacement: 1'b0,
                       last_of_run: 1'b0};
      end else if (!is_lead || item.end_of_input) begin
        fresh_put = 1'b1;
      end else begin
        bytes_remaining_next = trail;
        sequence_length_next = trail + 3'd1;
        code_accum_next      = {{(ACC_W-5){1'b0}}, lead_bits};
      end
      if (fresh_put) begin
        units[n[0]] = fresh_unit;
        n           = n + 2'd1;
      end
    end

    if (item.end_of_input) begin
      bytes_remaining_next = 3'd0;
      sequence_length_next = 3'd0;
      code_accum_next      = '0;
    end

    units[0].last_of_run = (n == 2'd1);
    units[1].last_of_run = (n == 2'd2);

    result.count = n;
    result.unit0 = units[0];
    result.unit1 = units[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 3'd0;
      sequence_length <= 3'd0;
      code_accum      <= '0;
    end else if (fire) begin
      bytes_remaining <= bytes_remaining_next;
      sequence_length <= sequence_length_next;
      code_accum      <= code_accum_next;
    end
  end

endmodule

// ===== src/u8u16_fifo.sv =====
`timescale 1ns / 1ps

module u8u16_fifo import u8u16_pkg::*; #(
  parameter int unsigned DEPTH = DEF_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic [1:0] push_count,
  input  out_item_t push0,
  input  out_item_t push1,
  output logic      room,
  output logic      valid,
  input  logic      ready,
  output out_item_t data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  out_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr1;
  logic [PTR_W-1:0] wr_ptr2;
  logic [PTR_W-1:0] rd_ptr1;
  logic [CNT_W-1:0] free;
  logic             pop;
  logic [CNT_W-1:0] add;

  always_comb begin
    wr_ptr1 = (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
    wr_ptr2 = (wr_ptr1 == LAST_PTR) ? '0 : wr_ptr1 + 1'b1;
    rd_ptr1 = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
    pop     = valid && ready;
    free    = CNT_W'(DEPTH) - count;
    // room for two units, counting the one leaving this cycle
    room    = (free >= CNT_W'(2)) || (free == CNT_W'(1) && pop);
    add     = push ? CNT_W'(push_count) : '0;
  end

  assign valid = (count != '0);
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push && push_count == 2'd2) begin
      mem[wr_ptr1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && push_count == 2'd1) begin
        wr_ptr <= wr_ptr1;
      end else if (push && push_count == 2'd2) begin
        wr_ptr <= wr_ptr2;
      end
      if (pop) begin
        rd_ptr <= rd_ptr1;
      end
      count <= count + add - (pop ? CNT_W'(1) : CNT_W'(0));
    end
  end

endmodule

// ===== src/utf8_to_utf16_transcoder_core.sv =====
`timescale 1ns / 1ps

// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+-------------------------------------
// byte     | in        | byte_valid / byte_ready | byte_item: in_byte, end_of_input
// unit     | out       | unit_valid / unit_ready | unit_item: code_unit, is_replacement,
//          |           |                         |            last_of_run
//
// one byte item is taken per cycle while byte_ready is high; each passes an input
// register, then the decode logic, which writes zero, one or two units into a small
// output queue, and its units leave from that queue
// a byte leaves the input register only when the queue has room for two units, so a
// stalled unit side backs up into byte_ready after a few items
// synchronous reset clears the input register, decoder state and the queue

module utf8_to_utf16_transcoder_core import u8u16_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  in_item_t  byte_item,
  output logic      unit_valid,
  input  logic      unit_ready,
  output out_item_t unit_item
);

  // input register
  logic        s1_valid;
  in_item_t    s1_item;

  logic        advance;
  logic        room;
  dec_result_t dec;

  // the registered byte moves on as soon as the queue can take its worst case
  assign advance    = s1_valid && room;
  assign byte_ready = !s1_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      s1_item <= byte_item;
    end
  end

  // sequence tracking and code unit generation
  u8u16_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (s1_item),
    .result (dec)
  );

  // output queue, decouples surrogate pairs and unit-side stalls
  u8u16_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (advance),
    .push_count (dec.count),
    .push0      (dec.unit0),
    .push1      (dec.unit1),
    .room       (room),
    .valid      (unit_valid),
    .ready      (unit_ready),
    .data       (unit_item)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import u8u16_pkg::*;

  // watchdog limit: ~1530 bytes, up to two units each, a receiver stalling a quarter of
  // the time plus one long hold-off; the limit is set far above what that run needs
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned RANDOM_BYTES = 1500;
  localparam int unsigned IDLE_PCT     = 24;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned HOLD_AT      = 900;
  localparam int unsigned STEADY_FROM  = 400;
  localparam int unsigned STEADY_TO    = 700;

  // code point limits, kept at the full accumulator width
  localparam logic [30:0] TWO_BYTE_MIN   = 31'h80;
  localparam logic [30:0] THREE_BYTE_MIN = 31'h800;
  localparam logic [30:0] SUPP_START     = 31'h10000;
  localparam logic [30:0] SURR_FIRST_CP  = 31'hD800;
  localparam logic [30:0] SURR_LAST_CP   = 31'hDFFF;
  localparam logic [30:0] NONCHAR_FFFE   = 31'hFFFE;
  localparam logic [30:0] NONCHAR_FFFF   = 31'hFFFF;
  localparam logic [30:0] TOP_CODE       = 31'h10FFFF;

  localparam logic [15:0] FFFD_UNIT = 16'hFFFD;
  localparam logic [15:0] HIGH_HALF = 16'hD800;
  localparam logic [15:0] LOW_HALF  = 16'hDC00;
  localparam logic [15:0] LOW_HALF_LAST_OF_HIGH = 16'hDBFF;

  // one byte waiting to be offered; drain_first holds it back until every unit is out
  typedef struct {
    in_item_t item;
    bit       drain_first;
  } byte_entry_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_ready;
  in_item_t  byte_item = '0;
  logic      unit_valid;
  logic      unit_ready = 1'b0;
  out_item_t unit_item;

  byte_entry_t pending_bytes[$];
  out_item_t   expected_units[$];
  out_item_t   step_units[$];

  // decoder state as the block should hold it
  logic [2:0]  cont_left = '0;
  logic [2:0]  seq_total = '0;
  logic [30:0] cp_accum  = '0;

  bit          byte_taken  = 1'b0;
  int unsigned bytes_taken = 0;
  int unsigned units_seen  = 0;
  int unsigned pair_count  = 0;
  int unsigned repl_count  = 0;
  int unsigned errors      = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 1'b0;
  bit          steady;

  utf8_to_utf16_transcoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .unit_valid (unit_valid),
    .unit_ready (unit_ready),
    .unit_item  (unit_item)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------------
  // expected behaviour of the decoder
  // ---------------------------------------------------------------------------------

  function automatic void push_unit(logic [15:0] cu, logic repl);
    out_item_t u;
    u.code_unit      = cu;
    u.is_replacement = repl;
    u.last_of_run    = 1'b0;
    step_units.push_back(u);
  endfunction

  function automatic void clear_decoder();
    cont_left = '0;
    seq_total = '0;
    cp_accum  = '0;
  endfunction

  // a complete sequence: reject overlong, five and six byte forms, surrogates,
  // the two noncharacters and anything past the last plane
  function automatic void close_sequence();
    logic [30:0] cp;
    logic [30:0] v;
    logic        bad;
    cp = cp_accum;
    case (seq_total)
      3'd2:    bad = cp < TWO_BYTE_MIN;
      3'd3:    bad = cp < THREE_BYTE_MIN;
      3'd4:    bad = cp < SUPP_START;
      default: bad = 1'b1;
    endcase
    if (cp >= SURR_FIRST_CP && cp <= SURR_LAST_CP) bad = 1'b1;
    if (cp == NONCHAR_FFFE || cp == NONCHAR_FFFF) bad = 1'b1;
    if (cp > TOP_CODE) bad = 1'b1;
    if (bad) begin
      push_unit(FFFD_UNIT, 1'b1);
    end else if (cp < SUPP_START) begin
      push_unit(cp[15:0], 1'b0);
    end else begin
      v = cp - SUPP_START;
      push_unit(HIGH_HALF + {6'b0, v[19:10]}, 1'b0);
      push_unit(LOW_HALF + {6'b0, v[9:0]}, 1'b0);
    end
    clear_decoder();
  endfunction

  // byte seen with no sequence open
  function automatic void start_fresh(logic [7:0] b, logic eoi);
    logic [2:0] trail;
    logic [4:0] lead_bits;
    bit         opens;
    opens     = 1'b1;
    trail     = '0;
    lead_bits = '0;
    casez (b)
      8'b0???????: begin
        push_unit({8'h00, b}, 1'b0);
        opens = 1'b0;
      end
      8'b110?????: begin
        trail     = 3'd1;
        lead_bits = b[4:0];
      end
      8'b1110????: begin
        trail     = 3'd2;
        lead_bits = {1'b0, b[3:0]};
      end
      8'b11110???: begin
        trail     = 3'd3;
        lead_bits = {2'b0, b[2:0]};
      end
      8'b111110??: begin
        trail     = 3'd4;
        lead_bits = {3'b0, b[1:0]};
      end
      8'b1111110?: begin
        trail     = 3'd5;
        lead_bits = {4'b0, b[0]};
      end
      default: begin
        // lone continuation, FE or FF
        push_unit(FFFD_UNIT, 1'b1);
        opens = 1'b0;
      end
    endcase
    if (opens) begin
      if (eoi) begin
        push_unit(FFFD_UNIT, 1'b1);
      end else begin
        cont_left = trail;
        seq_total = trail + 3'd1;
        cp_accum  = {26'b0, lead_bits};
      end
    end
  endfunction

  function automatic void predict_byte(in_item_t it);
    step_units.delete();
    if (cont_left != 3'd0) begin
      if (it.in_byte[7:6] == 2'b10) begin
        cp_accum  = {cp_accum[24:0], it.in_byte[5:0]};
        cont_left = cont_left - 3'd1;
        if (cont_left == 3'd0) begin
          close_sequence();
        end else if (it.end_of_input) begin
          push_unit(FFFD_UNIT, 1'b1);
          clear_decoder();
        end
      end else begin
        // sequence cut short: replace it, then decode this byte on its own
        push_unit(FFFD_UNIT, 1'b1);
        clear_decoder();
        start_fresh(it.in_byte, it.end_of_input);
      end
    end else begin
      start_fresh(it.in_byte, it.end_of_input);
    end
    if (it.end_of_input) clear_decoder();
    if (step_units.size() > 0) step_units[step_units.size() - 1].last_of_run = 1'b1;
    foreach (step_units[i]) expected_units.push_back(step_units[i]);
  endfunction

  // ---------------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------------

  task automatic add_byte(logic [7:0] b, logic eoi, bit drain);
    byte_entry_t e;
    e.item.in_byte      = b;
    e.item.end_of_input = eoi;
    e.drain_first       = drain;
    pending_bytes.push_back(e);
  endtask

  // continuation byte, leaning on the extremes of its six bits now and then
  function automatic logic [7:0] cont_byte();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'h80;
    if (r == 1) return 8'hBF;
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  function automatic logic [7:0] lead_byte(int unsigned len);
    case (len)
      2:       return 8'hC0 | 8'($urandom_range(31));
      3:       return 8'hE0 | 8'($urandom_range(15));
      // mostly F0..F4 so that valid supplementary characters are common
      4:       return 8'hF0 | 8'(($urandom_range(4) != 0) ? $urandom_range(4)
                                                         : $urandom_range(7));
      5:       return 8'hF8 | 8'($urandom_range(3));
      default: return 8'hFC | 8'($urandom_range(1));
    endcase
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return 2;
    if (r < 60) return 3;
    if (r < 90) return 4;
    return (r < 95) ? 5 : 6;
  endfunction

  task automatic add_segment(bit drain);
    int unsigned r;
    int unsigned len;
    int unsigned keep;
    logic [7:0]  b;
    r = $urandom_range(99);
    if (r < 30) begin
      add_byte(8'($urandom_range(127)), $urandom_range(49) == 0, drain);
    end else if (r < 80) begin
      // well-formed shape, random content
      len = pick_length();
      add_byte(lead_byte(len), 1'b0, drain);
      for (int unsigned i = 1; i < len; i++)
        add_byte(cont_byte(), (i == len - 1) && ($urandom_range(19) == 0), 1'b0);
    end else if (r < 92) begin
      // truncated sequence: cut by a fresh byte or by the end of the text
      len  = pick_length();
      keep = $urandom_range(len - 2);
      if ($urandom_range(1) == 0) begin
        add_byte(lead_byte(len), 1'b0, drain);
        for (int unsigned i = 0; i < keep; i++) add_byte(cont_byte(), 1'b0, 1'b0);
        do b = 8'($urandom_range(255)); while (b[7:6] == 2'b10);
        add_byte(b, $urandom_range(9) == 0, 1'b0);
      end else begin
        add_byte(lead_byte(len), keep == 0, drain);
        for (int unsigned i = 0; i < keep; i++) add_byte(cont_byte(), i == keep - 1, 1'b0);
      end
    end else begin
      add_byte(8'($urandom_range(255)), $urandom_range(19) == 0, drain);
    end
  endtask

  // ---------------------------------------------------------------------------------
  // byte side driver: changes on the falling edge, keeps an item steady until taken
  // ---------------------------------------------------------------------------------

  // no idling on either side for a stretch in the middle of the run
  assign steady = bytes_taken >= STEADY_FROM && bytes_taken < STEADY_TO;

  always @(negedge clk) begin
    bit          offer;
    byte_entry_t next_entry;
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || byte_taken) begin
      offer = pending_bytes.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT);
      if (offer && pending_bytes[0].drain_first && expected_units.size() != 0) offer = 1'b0;
      if (offer) begin
        next_entry = pending_bytes.pop_front();
        byte_item  <= next_entry.item;
        byte_valid <= 1'b1;
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // unit side: random back-pressure plus one long hold-off that fills the block
  // ---------------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      unit_ready <= 1'b0;
    end else if (hold_left != 0) begin
      unit_ready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && bytes_taken >= HOLD_AT) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      unit_ready <= 1'b0;
    end else begin
      unit_ready <= steady || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // ---------------------------------------------------------------------------------
  // monitor: predict on every byte taken, check every unit against the oldest one due
  // ---------------------------------------------------------------------------------

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= byte_valid && byte_ready;
      if (byte_valid && byte_ready) begin
        predict_byte(byte_item);
        bytes_taken <= bytes_taken + 1;
      end
      if (unit_valid && unit_ready) begin
        if (expected_units.size() == 0) begin
          $error("unexpected unit: code_unit %04h is_replacement %0b last_of_run %0b",
                 unit_item.code_unit, unit_item.is_replacement, unit_item.last_of_run);
          errors++;
        end else begin
          want = expected_units.pop_front();
          units_seen++;
          if (want.is_replacement) repl_count++;
          if (want.code_unit >= HIGH_HALF && want.code_unit <= LOW_HALF_LAST_OF_HIGH)
            pair_count++;
          if (unit_item.code_unit !== want.code_unit) begin
            $error("code_unit: expected %04h, got %04h", want.code_unit, unit_item.code_unit);
            errors++;
          end
          if (unit_item.is_replacement !== want.is_replacement) begin
            $error("is_replacement: expected %0b, got %0b",
                   want.is_replacement, unit_item.is_replacement);
            errors++;
          end
          if (unit_item.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b",
                   want.last_of_run, unit_item.last_of_run);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d units still due", cycle_count,
               expected_units.size());
      $display("utf8_to_utf16_transcoder_core verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------------

  initial begin
    int unsigned target;

    // directed: ascii extremes, each length that decodes, genuine U+FFFD,
    // highest code point, stray bytes, cut sequences and early end of text
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h7F, 1'b1, 1'b0);
    add_byte(8'hC2, 1'b0, 1'b0);  add_byte(8'hA9, 1'b0, 1'b0);
    add_byte(8'hE2, 1'b0, 1'b0);  add_byte(8'h82, 1'b0, 1'b0);  add_byte(8'hAC, 1'b0, 1'b0);
    add_byte(8'hEF, 1'b0, 1'b0);  add_byte(8'hBF, 1'b0, 1'b0);  add_byte(8'hBD, 1'b0, 1'b0);
    add_byte(8'hF0, 1'b0, 1'b0);  add_byte(8'h9F, 1'b0, 1'b0);
    add_byte(8'h98, 1'b0, 1'b0);  add_byte(8'h80, 1'b0, 1'b0);
    add_byte(8'hF4, 1'b0, 1'b0);  add_byte(8'h8F, 1'b0, 1'b0);
    add_byte(8'hBF, 1'b0, 1'b0);  add_byte(8'hBF, 1'b0, 1'b0);
    // lone continuation, FE, FF
    add_byte(8'h80, 1'b0, 1'b0);  add_byte(8'hFE, 1'b0, 1'b0);  add_byte(8'hFF, 1'b0, 1'b0);
    // three-byte form broken off by an ascii letter
    add_byte(8'hE2, 1'b0, 1'b0);  add_byte(8'h82, 1'b0, 1'b0);  add_byte(8'h41, 1'b0, 1'b0);
    // lead byte as the final byte, then end of text mid-sequence
    add_byte(8'hC3, 1'b1, 1'b0);
    add_byte(8'hF0, 1'b0, 1'b0);  add_byte(8'h90, 1'b1, 1'b0);

    // random part; the first segment waits for the directed units to drain
    target = pending_bytes.size() + RANDOM_BYTES;
    add_segment(1'b1);
    while (pending_bytes.size() < target) add_segment($urandom_range(149) == 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every byte offered and taken
    while (pending_bytes.size() != 0 || byte_valid) @(posedge clk);
    // every unit out, then a further wait to catch strays
    while (expected_units.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d bytes and checked %0d units", bytes_taken, units_seen);
    $display("including %0d surrogate pairs and %0d replacement units",
             pair_count, repl_count);
    if (errors == 0) begin
      $display("utf8_to_utf16_transcoder_core verification clean");
    end else begin
      $display("utf8_to_utf16_transcoder_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/u8u16_pkg.sv
src/u8u16_decode.sv
src/u8u16_fifo.sv
src/utf8_to_utf16_transcoder_core.sv
test/tb.sv
